// ===== hdl/mvpm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvpm_pkg
// Shared types, constants and the mu-law decoder for the voice playback mixer.
// ----------------------------------------------------------------------------
package mvpm_pkg;

  localparam int Players    = 16;
  localparam int QueueDepth = 8192;
  localparam int PW         = $clog2(Players);
  localparam int QW         = $clog2(QueueDepth);
  localparam int CW         = QW + 1;
  localparam int AW         = PW + QW;
  localparam int QueueLen   = 4;

  localparam logic [14:0] SpeakThreshold = 15'd700;
  localparam logic [3:0]  SpeakLoad      = 4'd12;
  localparam logic [6:0]  VolReset       = 7'd100;

  typedef enum logic [1:0] {
    FN_PUSH = 2'd0,
    FN_MIX  = 2'd1,
    FN_TICK = 2'd2,
    FN_MUTE = 2'd3
  } func_t;

  // one classified word in the queue between front and back
  typedef struct packed {
    func_t              func;
    logic [3:0]         player;
    logic signed [15:0] sample;
    logic               frame_last;
    logic               mute_on;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic               frame_odd;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } bst_t;

  // G.711 mu-law expansion
  function automatic logic signed [15:0] decode_mulaw(input logic [7:0] b);
    logic [7:0]  v;
    logic [15:0] mag;
    v   = ~b;
    mag = ((16'({v[3:0], 3'b000}) + 16'h84) << v[6:4]) - 16'h84;
    return v[7] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== hdl/mvpm_ram.sv =====
// ----------------------------------------------------------------------------
// mvpm_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module mvpm_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/mvpm_front.sv =====
// ----------------------------------------------------------------------------
// mvpm_front
// Accepts input words, decodes mu-law and pushes classified words to a FIFO.
// ----------------------------------------------------------------------------
module mvpm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_func,
  input  logic [3:0]           in_player,
  input  logic [7:0]           in_code_byte,
  input  logic                 in_frame_last,
  input  logic                 in_mute_on,
  input  logic signed [15:0]   in_left_in,
  input  logic signed [15:0]   in_right_in,
  input  logic                 in_frame_odd,
  output logic                 q_valid,
  input  logic                 q_pop,
  output mvpm_pkg::cmd_t       q_head
);
  localparam int LW = $clog2(mvpm_pkg::QueueLen);

  mvpm_pkg::cmd_t  fifo_r [mvpm_pkg::QueueLen];
  logic [LW-1:0]   wp_r, rp_r;
  logic [LW:0]     cnt_r;
  logic            push;
  mvpm_pkg::cmd_t  cmd;

  assign in_ready = (cnt_r != (LW+1)'(mvpm_pkg::QueueLen));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = fifo_r[rp_r];

  // classify and decode
  always_comb begin
    cmd.func       = mvpm_pkg::func_t'(in_func);
    cmd.player     = in_player;
    cmd.sample     = mvpm_pkg::decode_mulaw(in_code_byte);
    cmd.frame_last = in_frame_last;
    cmd.mute_on    = in_mute_on;
    cmd.left_in    = in_left_in;
    cmd.right_in   = in_right_in;
    cmd.frame_odd  = in_frame_odd;
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (LW+1)'(push) - (LW+1)'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop on empty queue");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (LW+1)'(mvpm_pkg::QueueLen)) else $error("queue overflow");
  a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> cnt_r != '0) else $error("stalled while empty");
endmodule

// ===== hdl/mvpm_back.sv =====
// ----------------------------------------------------------------------------
// mvpm_back
// Executes queued words: sample store, queue pointers, mixing and status.
// ----------------------------------------------------------------------------
module mvpm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [6:0]           volume,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  mvpm_pkg::cmd_t       q_head,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_left_out,
  output logic signed [15:0]   out_right_out,
  output logic [15:0]          out_speaking_mask,
  output logic [15:0]          out_mute_mask
);
  localparam int PW = mvpm_pkg::PW;
  localparam int CW = mvpm_pkg::CW;
  localparam int QW = mvpm_pkg::QW;
  localparam int AW = mvpm_pkg::AW;
  localparam int NP = mvpm_pkg::Players;

  mvpm_pkg::bst_t st_r, st_nxt;
  logic [CW-1:0]  rc_r [NP];
  logic [CW-1:0]  wc_r [NP];
  logic [NP-1:0]  mute_r;
  logic [3:0]     hold_r [NP];
  logic [14:0]    peak_r;
  logic [PW:0]    idx_r;
  logic signed [22:0] prod_r;
  logic signed [21:0] acc_r;
  logic           ovalid_r;
  logic signed [15:0] lo_r, ro_r;
  logic           odd_r;

  mvpm_pkg::cmd_t c;
  logic [PW-1:0]  pi;
  logic           pok, do_push;
  logic [14:0]    mag;
  logic [CW-1:0]  fill;
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [15:0]    rdata;
  logic           take;
  logic           ch_ok_r;
  logic [PW-1:0]  cur;
  logic signed [21:0] qt;
  logic signed [22:0] sl, sr;
  logic [15:0]    smask;

  assign c       = q_head;
  assign pi      = c.player[PW-1:0];
  assign pok     = ({1'b0, c.player} < 5'(NP));
  assign do_push = take && c.func == mvpm_pkg::FN_PUSH && pok && !mute_r[pi];
  assign mag     = c.sample[15] ? 15'(-c.sample) : c.sample[14:0];
  assign fill    = wc_r[pi] - rc_r[pi];
  assign we      = do_push;
  assign waddr   = {pi, wc_r[pi][QW-1:0]};
  assign cur     = idx_r[PW-1:0];
  assign raddr   = {cur, rc_r[cur][QW-1:0]};
  assign take    = (st_r == mvpm_pkg::ST_IDLE) && q_valid && !ovalid_r;
  assign q_pop   = take;

  mvpm_ram #(.Width(16), .Depth(NP * mvpm_pkg::QueueDepth)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(c.sample),
    .raddr(raddr), .rdata(rdata));

  // trunc(sample*volume/100) via reciprocal multiply; |prod| < 2^22
  always_comb begin
    logic [21:0] a;
    logic [53:0] m;
    a  = prod_r[22] ? 22'(-prod_r) : prod_r[21:0];
    m  = 54'(a) * 54'd2748779070;
    qt = prod_r[22] ? -$signed({6'd0, m[53:38]}) : $signed({6'd0, m[53:38]});
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mvpm_pkg::ST_IDLE: if (take && c.func == mvpm_pkg::FN_MIX && volume != '0)
                           st_nxt = mvpm_pkg::ST_RD;
      mvpm_pkg::ST_RD:  st_nxt = mvpm_pkg::ST_MUL;
      mvpm_pkg::ST_MUL: st_nxt = mvpm_pkg::ST_ACC;
      mvpm_pkg::ST_ACC: st_nxt = (idx_r == (PW+1)'(NP-1)) ? mvpm_pkg::ST_OUT
                                                          : mvpm_pkg::ST_RD;
      mvpm_pkg::ST_OUT: st_nxt = mvpm_pkg::ST_IDLE;
      default:          st_nxt = mvpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    smask = '0;
    for (int i = 0; i < NP; i++) smask[i] = (hold_r[i] != '0);
  end

  // game audio plus voice sum, before saturation
  assign sl = 23'(lo_r) + 23'(acc_r);
  assign sr = 23'(ro_r) + 23'(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= mvpm_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  // mix datapath registers
  always_ff @(posedge clk) begin
    if (st_r == mvpm_pkg::ST_RD) ch_ok_r <= !mute_r[cur] && (wc_r[cur] != rc_r[cur]);
    if (st_r == mvpm_pkg::ST_MUL)
      prod_r <= $signed(rdata) * $signed({1'b0, volume});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_r <= '0; peak_r <= '0; ovalid_r <= 1'b0; idx_r <= '0; acc_r <= '0;
      for (int i = 0; i < NP; i++) begin
        rc_r[i] <= '0; wc_r[i] <= '0; hold_r[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) ovalid_r <= 1'b0;
      if (take) begin
        lo_r <= c.left_in; ro_r <= c.right_in; odd_r <= c.frame_odd;
        unique case (c.func)
          mvpm_pkg::FN_PUSH: begin
            if (do_push) begin
              if (fill >= CW'(mvpm_pkg::QueueDepth)) rc_r[pi] <= rc_r[pi] + 1'b1;
              wc_r[pi] <= wc_r[pi] + 1'b1;
              if (c.frame_last && (mag > peak_r ? mag : peak_r) >= mvpm_pkg::SpeakThreshold)
                hold_r[pi] <= mvpm_pkg::SpeakLoad;
            end
            if (c.frame_last) peak_r <= '0;
            else if (do_push && mag > peak_r) peak_r <= mag;
            ovalid_r <= 1'b1;
          end
          mvpm_pkg::FN_MIX: begin
            idx_r <= '0; acc_r <= '0;
            if (volume == '0) ovalid_r <= 1'b1;
          end
          mvpm_pkg::FN_TICK: begin
            for (int i = 0; i < NP; i++)
              if (hold_r[i] != '0) hold_r[i] <= hold_r[i] - 1'b1;
            ovalid_r <= 1'b1;
          end
          mvpm_pkg::FN_MUTE: begin
            if (pok) begin
              mute_r[pi] <= c.mute_on;
              if (c.mute_on) begin rc_r[pi] <= '0; wc_r[pi] <= '0; end
            end
            ovalid_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (st_r == mvpm_pkg::ST_ACC) begin
        if (ch_ok_r) begin
          acc_r <= acc_r + qt;
          if (odd_r) rc_r[cur] <= rc_r[cur] + 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      if (st_r == mvpm_pkg::ST_OUT) begin
        lo_r <= (sl > 23'sd32767) ? 16'sh7fff : (sl < -23'sd32768) ? 16'sh8000 : sl[15:0];
        ro_r <= (sr > 23'sd32767) ? 16'sh7fff : (sr < -23'sd32768) ? 16'sh8000 : sr[15:0];
        ovalid_r <= 1'b1;
      end
    end
  end

  assign out_valid         = ovalid_r;
  assign out_left_out      = lo_r;
  assign out_right_out     = ro_r;
  assign out_speaking_mask = smask;
  assign out_mute_mask     = mute_r;

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != mvpm_pkg::ST_IDLE) |-> !q_pop) else $error("take while busy");
  a_out_after_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == mvpm_pkg::ST_OUT) |=> out_valid) else $error("mix result lost");
  a_no_take_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !q_pop) else $error("take with result pending");
endmodule

// ===== hdl/mulaw_voice_playback_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// mulaw_voice_playback_mixer_unit
// Per-player mu-law voice queues mixed into stereo game audio.
// ----------------------------------------------------------------------------
// Push, tick and mute words set the out_valid register as the back end takes
// them. A mix word runs store read, multiply, and scale and accumulate states
// for each player, then a saturation state sets out_valid; at volume zero the
// mix sets it directly. One word executes at a time; a 4-word FIFO decouples
// input acceptance. Reset (rst_n, synchronous) clears pointers, mute, speaking
// counters, peak and sets volume to 100; the sample store is not cleared.
module mulaw_voice_playback_mixer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_volume,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [3:0]         in_player,
  input  logic [7:0]         in_code_byte,
  input  logic               in_frame_last,
  input  logic               in_mute_on,
  input  logic signed [15:0] in_left_in,
  input  logic signed [15:0] in_right_in,
  input  logic               in_frame_odd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left_out,
  output logic signed [15:0] out_right_out,
  output logic [15:0]        out_speaking_mask,
  output logic [15:0]        out_mute_mask
);
  logic [6:0]     vol_r;
  logic           q_valid, q_pop;
  mvpm_pkg::cmd_t q_head;

  // volume register
  always_ff @(posedge clk) begin
    if (!rst_n)      vol_r <= mvpm_pkg::VolReset;
    else if (cfg_we) vol_r <= cfg_volume;
  end

  mvpm_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_player, .in_code_byte,
    .in_frame_last, .in_mute_on, .in_left_in, .in_right_in, .in_frame_odd,
    .q_valid, .q_pop, .q_head);

  mvpm_back u_back (
    .clk, .rst_n, .volume(vol_r), .q_valid, .q_pop, .q_head,
    .out_valid, .out_ready, .out_left_out, .out_right_out,
    .out_speaking_mask, .out_mute_mask);
endmodule

// ===== bench/tb_mulaw_voice_playback_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_mulaw_voice_playback_mixer_unit
// Self-checking bench for the mu-law voice playback mixer. Words of all four
// functions are driven over valid/ready, and a scoreboard keeps its own copy
// of the queues, mute flags, speaking counters, peak and volume. It predicts
// every result and compares it field by field. The bench runs phases at
// several volume settings and under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_mulaw_voice_playback_mixer_unit;

  localparam int Players   = mvpm_pkg::Players;
  localparam int QueueDepth = mvpm_pkg::QueueDepth;
  localparam int CountWrap = 2 * QueueDepth;

  typedef struct {
    mvpm_pkg::func_t    func;
    logic [3:0]         player;
    logic [7:0]         code;
    logic               last;
    logic               mute_on;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               odd;
  } voice_word_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [15:0]        speak;
    logic [15:0]        mute;
  } mix_result_t;

  // predicts mixer results and checks them in order
  class mixer_scoreboard;
    logic signed [15:0] store[];
    int                 rd_cnt[Players];
    int                 wr_cnt[Players];
    bit                 muted[Players];
    int                 hold[Players];
    int                 peak;
    int                 volume;
    mix_result_t        expected_q[$];
    int                 errors;

    function new();
      store = new[Players * QueueDepth];
      foreach (rd_cnt[i]) begin
        rd_cnt[i] = 0;
        wr_cnt[i] = 0;
        muted[i]  = 0;
        hold[i]   = 0;
      end
      peak   = 0;
      volume = int'(mvpm_pkg::VolReset);
      errors = 0;
    endfunction

    function int mulaw_expand(logic [7:0] b);
      logic [7:0] v;
      int         mag;
      v   = ~b;
      mag = ((int'(v[3:0]) << 3) + 'h84) << v[6:4];
      mag = mag - 'h84;
      return v[7] ? -mag : mag;
    endfunction

    function int clip16(int x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
    endfunction

    function void note_word(voice_word_t w);
      mix_result_t r;
      int          p, s, mag, acc, l, rt;
      p  = int'(w.player);
      l  = int'(w.left);
      rt = int'(w.right);
      case (w.func)
        mvpm_pkg::FN_PUSH: begin
          if (!muted[p]) begin
            s   = mulaw_expand(w.code);
            mag = (s < 0) ? -s : s;
            // full queue: drop oldest
            if (((wr_cnt[p] - rd_cnt[p] + CountWrap) % CountWrap) >= QueueDepth)
              rd_cnt[p] = (rd_cnt[p] + 1) % CountWrap;
            if (mag > peak) peak = mag;
            store[p * QueueDepth + wr_cnt[p] % QueueDepth] = s[15:0];
            wr_cnt[p] = (wr_cnt[p] + 1) % CountWrap;
            if (w.last && peak >= int'(mvpm_pkg::SpeakThreshold))
              hold[p] = int'(mvpm_pkg::SpeakLoad);
          end
          if (w.last) peak = 0;
        end
        mvpm_pkg::FN_MIX: begin
          if (volume != 0) begin
            acc = 0;
            for (int i = 0; i < Players; i++) begin
              if (muted[i] || wr_cnt[i] == rd_cnt[i]) continue;
              acc += (int'(store[i * QueueDepth + rd_cnt[i] % QueueDepth]) * volume) / 100;
              if (w.odd) rd_cnt[i] = (rd_cnt[i] + 1) % CountWrap;
            end
            l  = clip16(l + acc);
            rt = clip16(rt + acc);
          end
        end
        mvpm_pkg::FN_TICK: begin
          foreach (hold[i]) if (hold[i] > 0) hold[i]--;
        end
        default: begin
          muted[p] = w.mute_on;
          if (w.mute_on) begin
            rd_cnt[p] = 0;
            wr_cnt[p] = 0;
          end
        end
      endcase
      r.left  = l[15:0];
      r.right = rt[15:0];
      for (int i = 0; i < Players; i++) begin
        r.speak[i] = (hold[i] != 0);
        r.mute[i]  = muted[i];
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(mix_result_t a);
      mix_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: left %0d right %0d", a.left, a.right);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.left !== e.left) begin
        $error("left_out expected %0d actual %0d", e.left, a.left);
        errors++;
      end
      if (a.right !== e.right) begin
        $error("right_out expected %0d actual %0d", e.right, a.right);
        errors++;
      end
      if (a.speak !== e.speak) begin
        $error("speaking_mask expected %h actual %h", e.speak, a.speak);
        errors++;
      end
      if (a.mute !== e.mute) begin
        $error("mute_mask expected %h actual %h", e.mute, a.mute);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [6:0]         cfg_volume;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_func;
  logic [3:0]         in_player;
  logic [7:0]         in_code_byte;
  logic               in_frame_last;
  logic               in_mute_on;
  logic signed [15:0] in_left_in;
  logic signed [15:0] in_right_in;
  logic               in_frame_odd;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_left_out;
  logic signed [15:0] out_right_out;
  logic [15:0]        out_speaking_mask;
  logic [15:0]        out_mute_mask;

  mixer_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off_req;
  int  sent_words;

  mulaw_voice_playback_mixer_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_volume       (cfg_volume),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_player        (in_player),
    .in_code_byte     (in_code_byte),
    .in_frame_last    (in_frame_last),
    .in_mute_on       (in_mute_on),
    .in_left_in       (in_left_in),
    .in_right_in      (in_right_in),
    .in_frame_odd     (in_frame_odd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_out     (out_left_out),
    .out_right_out    (out_right_out),
    .out_speaking_mask(out_speaking_mask),
    .out_mute_mask    (out_mute_mask)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  initial begin
    #40000000;
    $display("[mulaw_voice_playback_mixer_unit] ERROR");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    mix_result_t r;
    if (rst_n && out_valid && out_ready) begin
      r.left  = out_left_out;
      r.right = out_right_out;
      r.speak = out_speaking_mask;
      r.mute  = out_mute_mask;
      sb.check_result(r);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // drive one word, wait for acceptance, then an optional idle gap
  task automatic send_word(voice_word_t w);
    int gap;
    in_valid      <= 1'b1;
    in_func       <= w.func;
    in_player     <= w.player;
    in_code_byte  <= w.code;
    in_frame_last <= w.last;
    in_mute_on    <= w.mute_on;
    in_left_in    <= w.left;
    in_right_in   <= w.right;
    in_frame_odd  <= w.odd;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    sent_words++;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic voice_word_t blank_word(mvpm_pkg::func_t f);
    voice_word_t w;
    w.func    = f;
    w.player  = 4'($urandom);
    w.code    = 8'($urandom);
    w.last    = 1'($urandom);
    w.mute_on = 1'($urandom);
    w.left    = 16'($urandom);
    w.right   = 16'($urandom);
    w.odd     = 1'($urandom);
    return w;
  endfunction

  task automatic push(int p, logic [7:0] code, logic last);
    voice_word_t w;
    w        = blank_word(mvpm_pkg::FN_PUSH);
    w.player = 4'(p);
    w.code   = code;
    w.last   = last;
    send_word(w);
  endtask

  task automatic mix(logic signed [15:0] l, logic signed [15:0] r, logic odd);
    voice_word_t w;
    w       = blank_word(mvpm_pkg::FN_MIX);
    w.left  = l;
    w.right = r;
    w.odd   = odd;
    send_word(w);
  endtask

  task automatic set_mute(int p, logic on);
    voice_word_t w;
    w         = blank_word(mvpm_pkg::FN_MUTE);
    w.player  = 4'(p);
    w.mute_on = on;
    send_word(w);
  endtask

  // idle point: every result back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_volume(logic [6:0] v);
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_volume <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    sb.volume = int'(v);
  endtask

  // one voice frame with random content; quiet frames stay under threshold
  task automatic send_frame();
    int         p, len;
    bit         quiet;
    logic [7:0] c;
    p     = $urandom_range(Players - 1);
    len   = $urandom_range(8, 1);
    quiet = ($urandom_range(99) < 30);
    for (int i = 0; i < len; i++) begin
      c = 8'($urandom);
      if (quiet) c[6:4] = 3'b111;
      push(p, c, i == len - 1);
    end
  endtask

  task automatic random_phase(int count);
    voice_word_t w;
    int          k, stop;
    stop = sent_words + count;
    while (sent_words < stop) begin
      k = $urandom_range(99);
      if (k < 50) send_frame();
      else if (k < 80) begin
        w = blank_word(mvpm_pkg::FN_MIX);
        if ($urandom_range(9) == 0) w.left = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        send_word(w);
      end else if (k < 90) send_word(blank_word(mvpm_pkg::FN_TICK));
      else if (k < 97) begin
        w = blank_word(mvpm_pkg::FN_MUTE);
        w.mute_on = ($urandom_range(99) < 40);
        send_word(w);
      end else begin
        // stray push, often without a frame end
        w = blank_word(mvpm_pkg::FN_PUSH);
        send_word(w);
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_volume     <= '0;
    in_valid       <= 1'b0;
    in_func        <= mvpm_pkg::FN_PUSH;
    in_player      <= '0;
    in_code_byte   <= '0;
    in_frame_last  <= 1'b0;
    in_mute_on     <= 1'b0;
    in_left_in     <= '0;
    in_right_in    <= '0;
    in_frame_odd   <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;
    sent_words     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: code extremes, speaking load, saturation, mute cases
    mix(16'sh7fff, 16'sh8000, 1'b1);            // all queues empty
    push(15, 8'h00, 1'b0);                     // largest negative
    push(15, 8'h80, 1'b1);                     // largest positive, loads counter
    push(0, 8'hff, 1'b0);                      // zero
    push(0, 8'h7f, 1'b1);                      // quiet frame, no load
    mix(16'sh7fff, 16'sh7fff, 1'b0);           // high inputs, no saturation, no advance
    mix(16'sh8000, 16'sh8000, 1'b1);           // saturate low, advance
    send_word(blank_word(mvpm_pkg::FN_TICK));
    set_mute(7, 1'b1);
    push(7, 8'h00, 1'b1);                      // muted push clears peak only
    push(3, 8'h8f, 1'b1);
    set_mute(3, 1'b1);                         // clears queue
    set_mute(3, 1'b0);
    push(4, 8'h12, 1'b0);
    set_mute(4, 1'b0);                         // unmute keeps queue
    mix(16'sd0, 16'sd0, 1'b1);
    set_mute(7, 1'b0);
    repeat (12) send_word(blank_word(mvpm_pkg::FN_TICK)); // counters run down
    drain();

    // long queue on one player, read back partly
    for (int i = 0; i < 40; i++) push(5, 8'($urandom), i % 16 == 15);
    mix(16'sd100, -16'sd100, 1'b1);
    mix(16'sd0, 16'sd0, 1'b0);
    set_mute(5, 1'b1);
    set_mute(5, 1'b0);
    drain();

    // random phases across volume and idle patterns
    random_phase(140);
    drain();
    set_volume(7'd127);
    send_idle_pct = 77;
    random_phase(140);
    drain();
    set_volume(7'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 77;
    random_phase(140);
    drain();
    set_volume(7'd1);
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    random_phase(140);
    // receiver holds off while words keep coming
    hold_off_req = 1'b1;
    send_idle_pct = 0;
    random_phase(30);
    drain();
    set_volume(7'd50);
    recv_stall_pct = 0;
    random_phase(120);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("[mulaw_voice_playback_mixer_unit] OK");
    else
      $display("[mulaw_voice_playback_mixer_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mvpm_pkg.sv
hdl/mvpm_ram.sv
hdl/mvpm_front.sv
hdl/mvpm_back.sv
hdl/mulaw_voice_playback_mixer_unit.sv
bench/tb_mulaw_voice_playback_mixer_unit.sv
